// ===== rtl/homogeneous_point_transform_assert.svh =====
// Assertion macros for the homogeneous point transform block.
// Used by modules that include this header; expects signals clock and reset in scope.
`ifndef HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`define HOMOGENEOUS_POINT_TRANSFORM_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define HPT_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define HPT_ASSERT_SEQ(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define HPT_ASSERT_IMPL(lbl, ante, cons, msg)
`define HPT_ASSERT_SEQ(lbl, ante, cons, msg)
`endif
`endif

// ===== rtl/hpt_pkg.sv =====
// Shared constants, types and the 32-bit clamp for the homogeneous point transform.
// No dependencies; imported by hpt_div and homogeneous_point_transform.
package hpt_pkg;

   localparam int FRAC_BITS  = 16;
   localparam int DATA_W     = 32;
   localparam int PROD_W     = 2 * DATA_W;
   // three shifted products plus a 32-bit bias, exact
   localparam int ACC_W      = PROD_W - FRAC_BITS + 2;
   // divider dividend magnitude is |c| << FRAC_BITS
   localparam int NUM_W      = DATA_W + FRAC_BITS;
   localparam int QUO_W      = NUM_W + 1;
   localparam int CLAMP_W    = (ACC_W > QUO_W) ? ACC_W : QUO_W;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 3 * DATA_W;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_AFFINE = 2'd1,
      OP_PROJ   = 2'd2
   } op_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              clamped;
   } clamp_type;

   function automatic clamp_type clamp_data(input logic signed [CLAMP_W-1:0] v);
      clamp_type r;
      logic      fits;
      fits = (&v[CLAMP_W-1:DATA_W-1]) | ~(|v[CLAMP_W-1:DATA_W-1]);
      r.clamped = ~fits;
      if (fits) begin
         r.value = v[DATA_W-1:0];
      end else begin
         r.value = {v[CLAMP_W-1], {(DATA_W-1){~v[CLAMP_W-1]}}};
      end
      return r;
   endfunction

endpackage

// ===== rtl/homogeneous_point_transform.sv =====
// Homogeneous point transform: 4x4 row-vector matrix store, shared multiply-accumulate
// sequencer and perspective divide. Depends on hpt_pkg, hpt_div and the assert header.
//
// Usage:
//  req channel: tuser is the operation (load entry, affine, projective). A load
//   writes one Q16.16 matrix entry and returns nothing; code 3 is dropped silently.
//  rsp channel: one transaction per affine or projective transform, carrying x, y, z
//   and the w-was-zero and saturated flags.
//  Sequencing: a load leaves the sequencer idle, so the next transaction is taken right after.
//   A column runs bias, then multiply and accumulate for each of three rows, then clamp.
//   Affine: 3 columns, then the result is handed to the output stage.
//   Projective: 4 columns, a w check, then three divisions on the one restoring
//   divider (48 quotient bits, one per cycle); when w is zero the divisions are
//   skipped and x, y, z are returned as zero.
//  A finished result sits in the rsp output register; the next transaction can be
//   taken while it waits. If the receiver stalls, the sequencer holds its result in
//   the output stage until the register frees up.
//  Reset (synchronous, active high) clears the matrix to zero and drops any result.
`include "homogeneous_point_transform_assert.svh"
module homogeneous_point_transform
   import hpt_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,  // [1:0] operation
   // [3:0] entry_index, [35:4] entry_value, [67:36] point_x, [99:68] point_y,
   // [131:100] point_z, [135:132] zero
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [31:0] out_x, [63:32] out_y, [95:64] out_z
   output logic [1:0]            rsp_tuser   // [0] w_was_zero, [1] saturated
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_BIAS,
      ST_MUL,
      ST_ACC,
      ST_COL_END,
      ST_WCHECK,
      ST_DIV_START,
      ST_DIV_WAIT
   } state_type;

   // out_pend_ff: finished result waiting for the output register
   state_type                state_ff;
   logic                     out_pend_ff;
   logic                     proj_ff;
   logic [1:0]               row_ff;
   logic [1:0]               col_ff;
   logic signed [DATA_W-1:0] matrix_ff [16];
   logic signed [DATA_W-1:0] pt_ff [3];
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [DATA_W-1:0]        c_ff [3];
   logic [DATA_W-1:0]        w_ff;
   logic                     sat_ff;
   logic                     wzero_ff;
   logic                     rsp_valid_ff;
   logic [RSP_DATA_W-1:0]    rsp_data_ff;
   logic [1:0]               rsp_user_ff;

   logic [3:0]               entry_index;
   logic [DATA_W-1:0]        entry_value;
   logic signed [DATA_W-1:0] mat_rd;
   logic signed [PROD_W-1:0] prod_in;
   clamp_type                acc_clamp;
   clamp_type                quo_clamp;
   logic                     div_start;
   logic                     div_done;
   logic signed [QUO_W-1:0]  div_quo;
   logic                     req_fire;
   logic                     xform_fire;
   logic                     load_fire;
   logic                     wzero_clean;

   assign entry_index = req_tdata[3:0];
   assign entry_value = req_tdata[DATA_W+3:4];
   assign req_tready  = (state_ff == ST_IDLE) && !out_pend_ff;
   assign req_fire    = req_tvalid && req_tready;
   assign xform_fire  = req_fire && (req_tuser == OP_AFFINE || req_tuser == OP_PROJ);
   assign load_fire   = req_fire && (req_tuser == OP_LOAD);
   assign wzero_clean = (rsp_tdata == '0) && !rsp_tuser[1];

   assign mat_rd    = matrix_ff[{row_ff, col_ff}];
   assign prod_in   = mat_rd * pt_ff[row_ff];
   assign acc_clamp = clamp_data(CLAMP_W'(acc_ff));
   assign quo_clamp = clamp_data(CLAMP_W'(div_quo));
   assign div_start = (state_ff == ST_DIV_START);

   hpt_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    ($signed(c_ff[col_ff])),
      .denom    ($signed(w_ff)),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_pend_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            matrix_ff[i] <= '0;
         end
      end else begin
         // result waits here until the output register is free
         if (out_pend_ff && (!rsp_valid_ff || rsp_tready)) begin
            rsp_data_ff  <= {c_ff[2], c_ff[1], c_ff[0]};
            rsp_user_ff  <= {sat_ff, wzero_ff};
            rsp_valid_ff <= 1'b1;
            out_pend_ff  <= 1'b0;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  case (op_type'(req_tuser))
                     OP_LOAD: matrix_ff[entry_index] <= entry_value;
                     OP_AFFINE, OP_PROJ: begin
                        proj_ff  <= (op_type'(req_tuser) == OP_PROJ);
                        pt_ff[0] <= req_tdata[2*DATA_W+3:DATA_W+4];
                        pt_ff[1] <= req_tdata[3*DATA_W+3:2*DATA_W+4];
                        pt_ff[2] <= req_tdata[4*DATA_W+3:3*DATA_W+4];
                        sat_ff   <= 1'b0;
                        wzero_ff <= 1'b0;
                        row_ff   <= 2'd3;
                        col_ff   <= 2'd0;
                        state_ff <= ST_BIAS;
                     end
                     default: ;
                  endcase
               end
            end
            ST_BIAS: begin
               // row 3 enters unshifted
               acc_ff   <= ACC_W'(mat_rd);
               row_ff   <= 2'd0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               prod_ff  <= prod_in;
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               acc_ff <= acc_ff + ACC_W'(prod_ff >>> FRAC_BITS);
               if (row_ff == 2'd2) begin
                  state_ff <= ST_COL_END;
               end else begin
                  row_ff   <= row_ff + 1'b1;
                  state_ff <= ST_MUL;
               end
            end
            ST_COL_END: begin
               sat_ff <= sat_ff | acc_clamp.clamped;
               if (col_ff == 2'd3) begin
                  w_ff     <= acc_clamp.value;
                  state_ff <= ST_WCHECK;
               end else begin
                  c_ff[col_ff] <= acc_clamp.value;
                  if (col_ff == 2'd2 && !proj_ff) begin
                     out_pend_ff <= 1'b1;
                     state_ff    <= ST_IDLE;
                  end else begin
                     col_ff   <= col_ff + 1'b1;
                     row_ff   <= 2'd3;
                     state_ff <= ST_BIAS;
                  end
               end
            end
            ST_WCHECK: begin
               if (w_ff == '0) begin
                  for (int k = 0; k < 3; k++) begin
                     c_ff[k] <= '0;
                  end
                  wzero_ff    <= 1'b1;
                  sat_ff      <= 1'b0;
                  out_pend_ff <= 1'b1;
                  state_ff    <= ST_IDLE;
               end else begin
                  col_ff   <= 2'd0;
                  state_ff <= ST_DIV_START;
               end
            end
            ST_DIV_START: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  c_ff[col_ff] <= quo_clamp.value;
                  sat_ff       <= sat_ff | quo_clamp.clamped;
                  if (col_ff == 2'd2) begin
                     out_pend_ff <= 1'b1;
                     state_ff    <= ST_IDLE;
                  end else begin
                     col_ff   <= col_ff + 1'b1;
                     state_ff <= ST_DIV_START;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `HPT_ASSERT_SEQ(a_xform_holds_off, xform_fire, !req_tready, "transform did not stall input")
   `HPT_ASSERT_SEQ(a_load_silent, load_fire && !rsp_tvalid, !rsp_tvalid, "load produced a result")
   `HPT_ASSERT_IMPL(a_div_nonzero, div_start, w_ff != '0, "divide started with zero w")
   `HPT_ASSERT_IMPL(a_div_done_expected, div_done, state_ff == ST_DIV_WAIT, "stray divider done")
   `HPT_ASSERT_IMPL(a_wzero_clean, rsp_tvalid && rsp_tuser[0], wzero_clean, "zero-w result not cleared")

endmodule

// ===== rtl/hpt_div.sv =====
// Iterative signed divider: (numer << FRAC_BITS) / denom, truncated toward zero.
// Restoring, one quotient bit per cycle. Depends on hpt_pkg.
module hpt_div
   import hpt_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] numer,
   input  logic signed [DATA_W-1:0] denom,
   output logic                     done,
   output logic signed [QUO_W-1:0]  quotient
);

   localparam int CNT_W = $clog2(NUM_W);

   typedef enum logic [1:0] {
      D_IDLE,
      D_RUN,
      D_FIN
   } div_state_type;

   div_state_type           state_ff;
   logic [CNT_W-1:0]        cnt_ff;
   logic [DATA_W-1:0]       rem_ff;
   logic [DATA_W-1:0]       den_ff;
   logic [NUM_W-1:0]        nq_ff;
   logic                    neg_ff;
   logic                    done_ff;
   logic signed [QUO_W-1:0] quo_ff;

   logic [DATA_W-1:0] mag_n;
   logic [DATA_W-1:0] mag_d;
   logic [DATA_W:0]   rem_sh;
   logic [DATA_W:0]   trial;
   logic              ge;

   // unsigned magnitudes; -2^31 maps to 2^31 correctly
   assign mag_n  = numer[DATA_W-1] ? (~numer + 1'b1) : numer;
   assign mag_d  = denom[DATA_W-1] ? (~denom + 1'b1) : denom;
   assign rem_sh = {rem_ff, nq_ff[NUM_W-1]};
   assign ge     = rem_sh >= {1'b0, den_ff};
   assign trial  = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            D_IDLE: begin
               if (start) begin
                  nq_ff    <= {mag_n, {FRAC_BITS{1'b0}}};
                  den_ff   <= mag_d;
                  rem_ff   <= '0;
                  neg_ff   <= numer[DATA_W-1] ^ denom[DATA_W-1];
                  cnt_ff   <= CNT_W'(NUM_W - 1);
                  state_ff <= D_RUN;
               end
            end
            D_RUN: begin
               rem_ff <= ge ? trial[DATA_W-1:0] : rem_sh[DATA_W-1:0];
               nq_ff  <= {nq_ff[NUM_W-2:0], ge};
               if (cnt_ff == '0) begin
                  state_ff <= D_FIN;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            D_FIN: begin
               quo_ff   <= neg_ff ? -$signed({1'b0, nq_ff}) : $signed({1'b0, nq_ff});
               done_ff  <= 1'b1;
               state_ff <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
